@@ design/ray_triangle_intersect_assert.svh @@
// Assertion macros used by the ray/triangle intersection top level.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`ifndef SYNTH
`define RTI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RTI_ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) not (prop)) \
    else $error("forbidden condition seen");
`else
`define RTI_ASSERT(name, prop)
`define RTI_ASSERT_NEVER(name, prop)
`endif
`endif

@@ design/rti_pkg.sv @@
// Shared widths, register codes and types of the ray/triangle intersection block.
package rti_pkg;
  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DIRW = 18;
  localparam int EPSW = 16;
  localparam int EW = CW + 1;
  localparam int HW = DIRW + EW + 1;
  localparam int QW = 2 * EW + 1;
  localparam int AW = EW + QW + 4;
  localparam int NW = AW + FB;
  localparam int DISTW = 31;
  localparam int DVW = AW + DISTW;
  localparam int HLW = HW / 2;
  localparam int QLW = (QW + 1) / 2;
  localparam int PDLW = EW + HLW + 1;
  localparam int PDHW = EW + HW - HLW;
  localparam int PVLW = DIRW + QLW + 1;
  localparam int PVHW = DIRW + QW - QLW;
  localparam int PTLW = EW + QLW + 1;
  localparam int PTHW = EW + QW - QLW;
  localparam int FRONT_STAGES = 8;
  localparam int LAT = FRONT_STAGES + DISTW + 1;
  localparam int PAW = 5;
  localparam int RIW = 3;

  typedef enum logic [RIW-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } rti_reg_e;

  typedef struct packed {
    logic miss;
    logic sat;
  } rti_tag_t;
endpackage

@@ design/rti_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the hit distance.
module rti_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [rti_pkg::NW-1:0]   num_i,
  input  logic [rti_pkg::AW-1:0]   den_i,
  input  rti_pkg::rti_tag_t        tag_i,
  output logic                     valid_o,
  output logic [rti_pkg::DISTW-1:0] quo_o,
  output rti_pkg::rti_tag_t        tag_o
);
  localparam int S = rti_pkg::DISTW;

  logic                        vld_q [S];
  logic [rti_pkg::DVW-1:0]     rem_q [S];
  logic [rti_pkg::AW-1:0]      den_q [S];
  logic [rti_pkg::DISTW-1:0]   quo_q [S];
  rti_pkg::rti_tag_t           tag_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic                      vin;
    logic [rti_pkg::DVW-1:0]   rin;
    logic [rti_pkg::AW-1:0]    din;
    logic [rti_pkg::DISTW-1:0] qin;
    rti_pkg::rti_tag_t         tin;
    logic [rti_pkg::DVW-1:0]   trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rti_pkg::DVW'(num_i);
      assign din = den_i;
      assign qin = '0;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
      assign tin = tag_q[k-1];
    end

    assign trial = rti_pkg::DVW'(din) << (S - 1 - k);
    assign ge = (rin >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rin - trial) : rin;
      den_q[k] <= din;
      quo_q[k] <= qin | (ge ? (rti_pkg::DISTW'(1) << (S - 1 - k)) : '0);
      tag_q[k] <= tin;
    end
  end

  assign valid_o = vld_q[S-1];
  assign quo_o = quo_q[S-1];
  assign tag_o = tag_q[S-1];
endmodule

@@ design/ray_triangle_intersect.sv @@
// Top level: exact fixed-point ray/triangle intersection pipeline with APB ray registers.
// An accepted request passes stages 1 to 8, the divider and the output register to valid_o.
// Throughput: one triangle per cycle; busy is always low, eight arithmetic stages feed
// a 31-stage divider that forms one distance bit per stage.
// Reset clears the stage valid bits and loads origin 0, direction (1,0,0), epsilon 7.
// The receiver cannot stall; every result is shown for exactly one cycle.
`include "ray_triangle_intersect_assert.svh"
module ray_triangle_intersect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rti_pkg::CW-1:0]   a_x_i,
  input  logic signed [rti_pkg::CW-1:0]   a_y_i,
  input  logic signed [rti_pkg::CW-1:0]   a_z_i,
  input  logic signed [rti_pkg::CW-1:0]   b_x_i,
  input  logic signed [rti_pkg::CW-1:0]   b_y_i,
  input  logic signed [rti_pkg::CW-1:0]   b_z_i,
  input  logic signed [rti_pkg::CW-1:0]   c_x_i,
  input  logic signed [rti_pkg::CW-1:0]   c_y_i,
  input  logic signed [rti_pkg::CW-1:0]   c_z_i,
  output logic                            valid_o,
  output logic                            hit_o,
  output logic [rti_pkg::DISTW-1:0]       distance_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rti_pkg::PAW-1:0]         paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  localparam int EW = rti_pkg::EW;
  localparam int AW = rti_pkg::AW;

  logic signed [rti_pkg::CW-1:0]   org_q [3];
  logic signed [rti_pkg::DIRW-1:0] dir_q [3];
  logic [rti_pkg::EPSW-1:0]        eps_q;
  logic                            wr_en;
  rti_pkg::rti_reg_e               ridx;

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign wr_en = psel && penable && pwrite;
  assign ridx = rti_pkg::rti_reg_e'(paddr[rti_pkg::PAW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= rti_pkg::DIRW'(65536);
      dir_q[1] <= '0;
      dir_q[2] <= '0;
      eps_q <= rti_pkg::EPSW'(7);
    end else if (wr_en) begin
      unique case (ridx)
        rti_pkg::REG_ORG_X: org_q[0] <= pwdata;
        rti_pkg::REG_ORG_Y: org_q[1] <= pwdata;
        rti_pkg::REG_ORG_Z: org_q[2] <= pwdata;
        rti_pkg::REG_DIR_X: dir_q[0] <= pwdata[rti_pkg::DIRW-1:0];
        rti_pkg::REG_DIR_Y: dir_q[1] <= pwdata[rti_pkg::DIRW-1:0];
        rti_pkg::REG_DIR_Z: dir_q[2] <= pwdata[rti_pkg::DIRW-1:0];
        rti_pkg::REG_EPS:   eps_q <= pwdata[rti_pkg::EPSW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rti_pkg::REG_ORG_X: prdata = org_q[0];
      rti_pkg::REG_ORG_Y: prdata = org_q[1];
      rti_pkg::REG_ORG_Z: prdata = org_q[2];
      rti_pkg::REG_DIR_X: prdata = 32'(unsigned'(dir_q[0]));
      rti_pkg::REG_DIR_Y: prdata = 32'(unsigned'(dir_q[1]));
      rti_pkg::REG_DIR_Z: prdata = 32'(unsigned'(dir_q[2]));
      rti_pkg::REG_EPS:   prdata = 32'(eps_q);
      default:            prdata = '0;
    endcase
  end

  // Stage 1: edges and origin offset.
  logic                  v1_q;
  logic signed [EW-1:0]  e1_1_q [3];
  logic signed [EW-1:0]  e2_1_q [3];
  logic signed [EW-1:0]  s_1_q [3];
  logic signed [rti_pkg::CW-1:0] av [3];
  logic signed [rti_pkg::CW-1:0] bv [3];
  logic signed [rti_pkg::CW-1:0] cv [3];

  assign av = '{a_x_i, a_y_i, a_z_i};
  assign bv = '{b_x_i, b_y_i, b_z_i};
  assign cv = '{c_x_i, c_y_i, c_z_i};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_1_q[i] <= EW'(bv[i]) - EW'(av[i]);
      e2_1_q[i] <= EW'(cv[i]) - EW'(av[i]);
      s_1_q[i] <= EW'(org_q[i]) - EW'(av[i]);
    end
  end

  // Stage 2: cross product terms of h = dir x e2 and q = s x e1.
  logic                                  v2_q;
  logic signed [rti_pkg::DIRW+EW-1:0]    ph_q [6];
  logic signed [2*EW-1:0]                pq_q [6];
  logic signed [EW-1:0]                  e1_2_q [3];
  logic signed [EW-1:0]                  e2_2_q [3];
  logic signed [EW-1:0]                  s_2_q [3];

  always_ff @(posedge clk_i) begin
    ph_q[0] <= dir_q[1] * e2_1_q[2];
    ph_q[1] <= dir_q[2] * e2_1_q[1];
    ph_q[2] <= dir_q[2] * e2_1_q[0];
    ph_q[3] <= dir_q[0] * e2_1_q[2];
    ph_q[4] <= dir_q[0] * e2_1_q[1];
    ph_q[5] <= dir_q[1] * e2_1_q[0];
    pq_q[0] <= s_1_q[1] * e1_1_q[2];
    pq_q[1] <= s_1_q[2] * e1_1_q[1];
    pq_q[2] <= s_1_q[2] * e1_1_q[0];
    pq_q[3] <= s_1_q[0] * e1_1_q[2];
    pq_q[4] <= s_1_q[0] * e1_1_q[1];
    pq_q[5] <= s_1_q[1] * e1_1_q[0];
    e1_2_q <= e1_1_q;
    e2_2_q <= e2_1_q;
    s_2_q <= s_1_q;
  end

  // Stage 3: h and q.
  logic                              v3_q;
  logic signed [rti_pkg::HW-1:0]     h_q [3];
  logic signed [rti_pkg::QW-1:0]     q_q [3];
  logic signed [EW-1:0]              e1_3_q [3];
  logic signed [EW-1:0]              e2_3_q [3];
  logic signed [EW-1:0]              s_3_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      h_q[i] <= rti_pkg::HW'(ph_q[2*i]) - rti_pkg::HW'(ph_q[2*i+1]);
      q_q[i] <= rti_pkg::QW'(pq_q[2*i]) - rti_pkg::QW'(pq_q[2*i+1]);
    end
    e1_3_q <= e1_2_q;
    e2_3_q <= e2_2_q;
    s_3_q <= s_2_q;
  end

  // Stage 4: dot product terms against the low and high halves of h and q.
  logic                             v4_q;
  logic signed [rti_pkg::PDLW-1:0]  pdl_q [3];
  logic signed [rti_pkg::PDHW-1:0]  pdh_q [3];
  logic signed [rti_pkg::PDLW-1:0]  pul_q [3];
  logic signed [rti_pkg::PDHW-1:0]  puh_q [3];
  logic signed [rti_pkg::PVLW-1:0]  pvl_q [3];
  logic signed [rti_pkg::PVHW-1:0]  pvh_q [3];
  logic signed [rti_pkg::PTLW-1:0]  ptl_q [3];
  logic signed [rti_pkg::PTHW-1:0]  pth_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pdl_q[i] <= e1_3_q[i] * $signed({1'b0, h_q[i][rti_pkg::HLW-1:0]});
      pdh_q[i] <= e1_3_q[i] * $signed(h_q[i][rti_pkg::HW-1:rti_pkg::HLW]);
      pul_q[i] <= s_3_q[i] * $signed({1'b0, h_q[i][rti_pkg::HLW-1:0]});
      puh_q[i] <= s_3_q[i] * $signed(h_q[i][rti_pkg::HW-1:rti_pkg::HLW]);
      pvl_q[i] <= dir_q[i] * $signed({1'b0, q_q[i][rti_pkg::QLW-1:0]});
      pvh_q[i] <= dir_q[i] * $signed(q_q[i][rti_pkg::QW-1:rti_pkg::QLW]);
      ptl_q[i] <= e2_3_q[i] * $signed({1'b0, q_q[i][rti_pkg::QLW-1:0]});
      pth_q[i] <= e2_3_q[i] * $signed(q_q[i][rti_pkg::QW-1:rti_pkg::QLW]);
    end
  end

  // Stage 5: full dot product terms.
  logic                  v5_q;
  logic signed [AW-1:0]  pd_q [3];
  logic signed [AW-1:0]  pu_q [3];
  logic signed [AW-1:0]  pv_q [3];
  logic signed [AW-1:0]  pt_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pd_q[i] <= (AW'(pdh_q[i]) <<< rti_pkg::HLW) + AW'(pdl_q[i]);
      pu_q[i] <= (AW'(puh_q[i]) <<< rti_pkg::HLW) + AW'(pul_q[i]);
      pv_q[i] <= (AW'(pvh_q[i]) <<< rti_pkg::QLW) + AW'(pvl_q[i]);
      pt_q[i] <= (AW'(pth_q[i]) <<< rti_pkg::QLW) + AW'(ptl_q[i]);
    end
  end

  // Stage 6: determinant and numerators.
  logic                  v6_q;
  logic signed [AW-1:0]  det_q, un_q, vn_q, tn_q;

  always_ff @(posedge clk_i) begin
    det_q <= pd_q[0] + pd_q[1] + pd_q[2];
    un_q <= pu_q[0] + pu_q[1] + pu_q[2];
    vn_q <= pv_q[0] + pv_q[1] + pv_q[2];
    tn_q <= pt_q[0] + pt_q[1] + pt_q[2];
  end

  // Stage 7: make the determinant non-negative and flag a zero determinant.
  logic                  v7_q, zero7_q;
  logic signed [AW-1:0]  det7_q, un7_q, vn7_q, tn7_q;
  logic                  flip;

  assign flip = det_q[AW-1];

  always_ff @(posedge clk_i) begin
    zero7_q <= (det_q == '0);
    det7_q <= flip ? -det_q : det_q;
    un7_q <= flip ? -un_q : un_q;
    vn7_q <= flip ? -vn_q : vn_q;
    tn7_q <= flip ? -tn_q : tn_q;
  end

  // Stage 8: range tests and saturation check.
  logic                     v8_q;
  rti_pkg::rti_tag_t        tag8_q;
  logic [rti_pkg::NW-1:0]   num8_q;
  logic [AW-1:0]            den8_q;
  logic signed [AW-1:0]     eps_scaled;
  logic                     miss8;

  assign eps_scaled = AW'(eps_q) << (2 * rti_pkg::FB);
  assign miss8 = zero7_q || (det7_q < eps_scaled) || un7_q[AW-1] || (un7_q > det7_q)
                 || vn7_q[AW-1] || ((un7_q + vn7_q) > det7_q) || (tn7_q <= 0);

  always_ff @(posedge clk_i) begin
    tag8_q.miss <= miss8;
    tag8_q.sat <= (rti_pkg::DVW'(unsigned'(tn7_q))
                   >= (rti_pkg::DVW'(unsigned'(det7_q)) << (rti_pkg::DISTW - rti_pkg::FB)));
    num8_q <= rti_pkg::NW'(unsigned'(tn7_q)) << rti_pkg::FB;
    den8_q <= unsigned'(det7_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  logic                        dv;
  logic [rti_pkg::DISTW-1:0]   quo;
  rti_pkg::rti_tag_t           dtag;
  logic [rti_pkg::DISTW-1:0]   dist_sel;
  logic                        hit;

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (num8_q),
    .den_i   (den8_q),
    .tag_i   (tag8_q),
    .valid_o (dv),
    .quo_o   (quo),
    .tag_o   (dtag)
  );

  assign dist_sel = dtag.sat ? '1 : quo;
  assign hit = !dtag.miss && (dist_sel > rti_pkg::DISTW'(eps_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      hit_o <= 1'b0;
      distance_o <= '0;
    end else begin
      valid_o <= dv;
      hit_o <= dv && hit;
      distance_o <= (dv && hit) ? dist_sel : '0;
    end
  end

  `RTI_ASSERT(a_latency, start |-> ##(rti_pkg::LAT) valid_o)
  `RTI_ASSERT(a_miss_zero, (valid_o && !hit_o) |-> (distance_o == '0))
  `RTI_ASSERT_NEVER(a_hit_without_strobe, hit_o && !valid_o)
  `RTI_ASSERT(a_hit_nonzero, hit_o |-> (distance_o != '0))
endmodule

@@ test/rti_checker.sv @@
// Checker for the ray/triangle intersection block: tracks the ray registers and scores results.
module rti_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [rti_pkg::CW-1:0] a_x_i,
  input  logic signed [rti_pkg::CW-1:0] a_y_i,
  input  logic signed [rti_pkg::CW-1:0] a_z_i,
  input  logic signed [rti_pkg::CW-1:0] b_x_i,
  input  logic signed [rti_pkg::CW-1:0] b_y_i,
  input  logic signed [rti_pkg::CW-1:0] b_z_i,
  input  logic signed [rti_pkg::CW-1:0] c_x_i,
  input  logic signed [rti_pkg::CW-1:0] c_y_i,
  input  logic signed [rti_pkg::CW-1:0] c_z_i,
  input  logic                          valid_o,
  input  logic                          hit_o,
  input  logic [rti_pkg::DISTW-1:0]     distance_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rti_pkg::PAW-1:0]       paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending,
  output int                            hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wint_t;
  typedef struct {
    wint_t x;
    wint_t y;
    wint_t z;
  } wvec_t;
  typedef struct {
    logic                      hit;
    logic [rti_pkg::DISTW-1:0] distance;
  } hit_info_t;

  logic signed [rti_pkg::CW-1:0]   org_r [3];
  logic signed [rti_pkg::DIRW-1:0] dir_r [3];
  logic [rti_pkg::EPSW-1:0]        eps_r;
  hit_info_t                       expected_q [$];

  function automatic wvec_t vsub(wvec_t p, wvec_t r);
    wvec_t o;
    o.x = p.x - r.x;
    o.y = p.y - r.y;
    o.z = p.z - r.z;
    return o;
  endfunction

  function automatic wvec_t vcross(wvec_t p, wvec_t r);
    wvec_t o;
    o.x = p.y * r.z - p.z * r.y;
    o.y = p.z * r.x - p.x * r.z;
    o.z = p.x * r.y - p.y * r.x;
    return o;
  endfunction

  function automatic wint_t vdot(wvec_t p, wvec_t r);
    return p.x * r.x + p.y * r.y + p.z * r.z;
  endfunction

  function automatic hit_info_t trace_triangle(logic signed [rti_pkg::CW-1:0] v [9]);
    hit_info_t res;
    wvec_t     o, d, va, vb, vc, e1, e2, s, h, q;
    wint_t     det, un, vn, tn, num, quo, epsw;
    o.x = wint_t'(org_r[0]);
    o.y = wint_t'(org_r[1]);
    o.z = wint_t'(org_r[2]);
    d.x = wint_t'(dir_r[0]);
    d.y = wint_t'(dir_r[1]);
    d.z = wint_t'(dir_r[2]);
    va.x = wint_t'(v[0]);
    va.y = wint_t'(v[1]);
    va.z = wint_t'(v[2]);
    vb.x = wint_t'(v[3]);
    vb.y = wint_t'(v[4]);
    vb.z = wint_t'(v[5]);
    vc.x = wint_t'(v[6]);
    vc.y = wint_t'(v[7]);
    vc.z = wint_t'(v[8]);
    res.hit = 1'b0;
    res.distance = '0;
    epsw = wint_t'({1'b0, eps_r});
    e1 = vsub(vb, va);
    e2 = vsub(vc, va);
    s = vsub(o, va);
    h = vcross(d, e2);
    det = vdot(e1, h);
    if (det == 0) return res;
    un = vdot(s, h);
    q = vcross(s, e1);
    vn = vdot(d, q);
    tn = vdot(e2, q);
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    if (det < (epsw <<< (2 * rti_pkg::FB))) return res;
    if (un < 0 || un > det) return res;
    if (vn < 0 || un + vn > det) return res;
    if (tn <= 0) return res;
    num = tn <<< rti_pkg::FB;
    if (num >= (det <<< rti_pkg::DISTW)) begin
      res.distance = '1;
    end else begin
      quo = num / det;
      res.distance = quo[rti_pkg::DISTW-1:0];
    end
    if (res.distance <= {15'd0, eps_r}) begin
      res.distance = '0;
      return res;
    end
    res.hit = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : p_score
    logic signed [rti_pkg::CW-1:0] verts [9];
    hit_info_t                     exp_r;
    int                            bad;
    if (!rst_ni) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= rti_pkg::DIRW'(65536);
      dir_r[1] <= '0;
      dir_r[2] <= '0;
      eps_r <= rti_pkg::EPSW'(7);
      expected_q.delete();
      errors <= 0;
      hits <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (psel && penable && pwrite && pready) begin
        case (paddr[rti_pkg::PAW-1:2])
          rti_pkg::REG_ORG_X: org_r[0] <= pwdata[rti_pkg::CW-1:0];
          rti_pkg::REG_ORG_Y: org_r[1] <= pwdata[rti_pkg::CW-1:0];
          rti_pkg::REG_ORG_Z: org_r[2] <= pwdata[rti_pkg::CW-1:0];
          rti_pkg::REG_DIR_X: dir_r[0] <= pwdata[rti_pkg::DIRW-1:0];
          rti_pkg::REG_DIR_Y: dir_r[1] <= pwdata[rti_pkg::DIRW-1:0];
          rti_pkg::REG_DIR_Z: dir_r[2] <= pwdata[rti_pkg::DIRW-1:0];
          rti_pkg::REG_EPS:   eps_r <= pwdata[rti_pkg::EPSW-1:0];
          default: ;
        endcase
      end
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request waiting: hit %0b distance %0d",
                   $realtime, hit_o, distance_o);
          bad++;
        end else begin
          exp_r = expected_q.pop_front();
          if (hit_o) hits <= hits + 1;
          if (hit_o !== exp_r.hit) begin
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $realtime, exp_r.hit, hit_o);
            bad++;
          end
          if (distance_o !== exp_r.distance) begin
            $display("%0t: distance mismatch: expected %0d actual %0d",
                     $realtime, exp_r.distance, distance_o);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        verts = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};
        expected_q = {expected_q, trace_triangle(verts)};
      end
      errors <= errors + bad;
      pending <= expected_q.size();
    end
  end
endmodule

@@ test/tb_ray_triangle_intersect.sv @@
// Testbench top: drives rays and triangles into the intersection block and gives the verdict.
module tb_ray_triangle_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_RAY = 190;

  logic                          clk_i, rst_ni, start, busy;
  logic signed [rti_pkg::CW-1:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i;
  logic                          valid_o, hit_o;
  logic [rti_pkg::DISTW-1:0]     distance_o;
  logic                          psel, penable, pwrite, pready;
  logic [rti_pkg::PAW-1:0]       paddr;
  logic [31:0]                   pwdata, prdata;
  int                            errors, pending, hits;
  int                            triangles_sent, rays_set;
  logic                          idle_on;
  int                            quiet_cycles;
  longint                        ray_org [3];
  longint                        ray_dir [3];

  ray_triangle_intersect u_top (.*);

  rti_checker u_checker (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .c_x_i, .c_y_i, .c_z_i,
    .valid_o, .hit_o, .distance_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .hits
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] fx(int n);
    return 32'(n) << rti_pkg::FB;
  endfunction

  task automatic reg_write(rti_pkg::rti_reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rti_pkg::PAW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [31:0] eps);
    reg_write(rti_pkg::REG_ORG_X, 32'(ox));
    reg_write(rti_pkg::REG_ORG_Y, 32'(oy));
    reg_write(rti_pkg::REG_ORG_Z, 32'(oz));
    reg_write(rti_pkg::REG_DIR_X, dx);
    reg_write(rti_pkg::REG_DIR_Y, dy);
    reg_write(rti_pkg::REG_DIR_Z, dz);
    reg_write(rti_pkg::REG_EPS, eps);
    ray_org = '{longint'(signed'(32'(ox))), longint'(signed'(32'(oy))),
                longint'(signed'(32'(oz)))};
    ray_dir = '{longint'(signed'(dx[rti_pkg::DIRW-1:0])),
                longint'(signed'(dy[rti_pkg::DIRW-1:0])),
                longint'(signed'(dz[rti_pkg::DIRW-1:0]))};
    rays_set++;
  endtask

  task automatic send_triangle(logic [31:0] v [9]);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start <= 1'b1;
    {a_x_i, a_y_i, a_z_i} <= {v[0], v[1], v[2]};
    {b_x_i, b_y_i, b_z_i} <= {v[3], v[4], v[5]};
    {c_x_i, c_y_i, c_z_i} <= {v[6], v[7], v[8]};
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    triangles_sent++;
  endtask

  task automatic send_fx(int ax, int ay, int az, int bx, int by, int bz,
                         int cx, int cy, int cz);
    logic [31:0] v [9];
    v = '{fx(ax), fx(ay), fx(az), fx(bx), fx(by), fx(bz), fx(cx), fx(cy), fx(cz)};
    send_triangle(v);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (rti_pkg::LAT + 4) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [31:0] v [9];
    longint      center [3];
    longint      kraw;
    int          sh;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        foreach (v[i]) v[i] = $urandom();
      end else begin
        kraw = longint'($urandom_range(1, 1 << $urandom_range(10, 24)));
        foreach (center[i]) center[i] = ray_org[i] + ((ray_dir[i] * kraw) >>> rti_pkg::FB);
        sh = $urandom_range(6, 22);
        foreach (v[i]) v[i] = 32'(center[i % 3] + longint'($urandom_range(0, 2 << sh))
                                  - (longint'(1) << sh));
      end
      send_triangle(v);
    end
  endtask

  initial begin
    logic [31:0] v [9];
    rst_ni = 1'b0;
    start = 1'b0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    triangles_sent = 0;
    rays_set = 0;
    ray_org = '{0, 0, 0};
    ray_dir = '{65536, 0, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ray: origin at zero looking along +x with epsilon 7.
    send_fx(5, -1, -1, 5, 2, -1, 5, -1, 2);
    send_fx(5, 1, -1, 5, 4, -1, 5, 1, 2);
    send_fx(5, -3, -3, 5, -2, -3, 5, -3, -2);
    send_fx(5, -1, 1, 5, 2, 1, 5, -1, 4);
    send_fx(5, -2, -2, 5, 2, -2, 5, -2, 1);
    send_fx(-5, -1, -1, -5, 2, -1, -5, -1, 2);
    send_fx(3, 3, 3, 3, 3, 3, 3, 3, 3);
    send_fx(1, 0, 0, 5, 0, 0, 1, 0, 5);
    send_fx(5, 0, 0, 5, 1, 0, 5, 0, 1);
    v = '{32'd7, fx(-1), fx(-1), 32'd7, fx(2), fx(-1), 32'd7, fx(-1), fx(2)};
    send_triangle(v);
    v = '{32'd8, fx(-1), fx(-1), 32'd8, fx(2), fx(-1), 32'd8, fx(-1), fx(2)};
    send_triangle(v);
    v = '{fx(5), -32'sd1, -32'sd1, fx(5), 32'd2, -32'sd1, fx(5), -32'sd1, 32'd2};
    send_triangle(v);
    foreach (v[i]) v[i] = 32'h7fff_ffff;
    send_triangle(v);
    foreach (v[i]) v[i] = 32'h8000_0000;
    send_triangle(v);
    v = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff,
          32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0000};
    send_triangle(v);
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    send_triangle(v);
    send_random(RANDOM_PER_RAY);
    drain();

    // A direction of one raw step makes every far hit saturate.
    reg_write(rti_pkg::rti_reg_e'(3'd7), 32'hffff_ffff);
    set_ray(0, 0, 0, 32'd1, 32'd0, 32'd0, 32'd7);
    send_fx(5, -1, -1, 5, 2, -1, 5, -1, 2);
    send_fx(30000, -1, -1, 30000, 2, -1, 30000, -1, 2);
    send_fx(-5, -1, -1, -5, 2, -1, -5, -1, 2);
    send_random(RANDOM_PER_RAY);
    drain();

    set_ray(longint'($urandom()) - 64'h8000_0000, longint'($urandom_range(0, 1 << 24)),
            -longint'($urandom_range(0, 1 << 24)), 32'($urandom_range(0, 131072) - 65536),
            32'($urandom_range(0, 131072) - 65536), 32'($urandom_range(0, 131072) - 65536),
            $urandom_range(0, 65535));
    send_random(RANDOM_PER_RAY);
    drain();

    set_ray(64'h7fff_ffff, -64'h8000_0000, 0, 32'hfffe_0000 | 32'h3_0000, 32'd65536,
            32'hfffe_0000 | 32'h3_0000, 32'd0);
    send_fx(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_random(RANDOM_PER_RAY);
    drain();

    set_ray(fx(-3), fx(2), fx(1), 32'hfffc_0000 | 32'd65536, 32'hffff_0000,
            32'h1234_0000, 32'hffff_ffff);
    send_fx(60000, -1, -1, 60000, 2, -1, 60000, -1, 2);
    send_random(RANDOM_PER_RAY);
    drain();

    // Final stretch runs back to back with no gaps.
    idle_on = 1'b0;
    set_ray(fx(1), fx(-1), fx(-100), 32'd0, 32'd0, 32'd65536, 32'd7);
    send_random(RANDOM_PER_RAY);
    drain();

    $display("Sent %0d triangles against %0d programmed rays plus the reset ray.",
             triangles_sent, rays_set);
    $display("Saw %0d hits; the rest were misses of every kind.", hits);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o || (psel && penable) || !rst_ni) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end
endmodule

@@ ray_triangle_intersect.f @@
+incdir+design
design/rti_pkg.sv
design/rti_div.sv
design/ray_triangle_intersect.sv
test/rti_checker.sv
test/tb_ray_triangle_intersect.sv
